[src/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // replacement character and surrogate prefixes
    localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
    localparam logic [5:0]  HI_SURR_PREFIX = 6'b110110;
    localparam logic [5:0]  LO_SURR_PREFIX = 6'b110111;

    // code point thresholds
    localparam logic [30:0] CP_SURR_LO     = 31'h0000D800;
    localparam logic [30:0] CP_SURR_HI     = 31'h0000DFFF;
    localparam logic [30:0] CP_NONCHAR     = 31'h0000FFFE;
    localparam logic [30:0] CP_MAX         = 31'h0010FFFF;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

    // input beat: one UTF-8 byte
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_beat;

    // output beat: one UTF-16 code unit
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } t_out_beat;

    // sequence state carried between bytes
    typedef struct packed {
        logic [30:0] partial_value;
        logic [2:0]  trail_remaining;
        logic [2:0]  sequence_trails;
    } t_seq_state;

    // decoder result for one byte: up to two code units and the new state
    typedef struct packed {
        logic [1:0]  unit_cnt;
        logic [15:0] unit0;
        logic [15:0] unit1;
        t_seq_state  nxt;
    } t_dec_result;

    // smallest legal code point for a sequence with the given trail count
    function automatic logic [30:0] least_value(input logic [2:0] trails);
        logic [30:0] v;
        v = '0;
        case (trails)
            3'd1:    v = 31'h00000080;
            3'd2:    v = 31'h00000800;
            3'd3:    v = 31'h00010000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/utf8_to_utf16_transcoder_top.sv]
// An accepted byte is held in the input register, and its code units leave from the
// result register. Throughput: one byte per cycle while the output is not stalled; a
// byte that yields units waits behind a two-unit result, as the port moves one unit per cycle.
// Reset: synchronous active-low i_rst_n empties both stages and returns the
// decoder to the idle state between sequences.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units out, with an input register, a
// single decode step and a two-entry result register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  u8u16_pkg::t_in_beat   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output u8u16_pkg::t_out_beat  o_out
);

    logic                   r_in_vld, n_in_vld;
    u8u16_pkg::t_in_beat    r_in, n_in;
    u8u16_pkg::t_seq_state  r_seq, n_seq;
    logic [1:0]             r_cnt, n_cnt;
    logic [15:0]            r_u0, n_u0;
    logic [15:0]            r_u1, n_u1;
    u8u16_pkg::t_dec_result dec;
    logic                   out_acc;
    logic                   res_free;
    logic                   consume;
    logic                   in_acc;

    // decode of the registered byte
    u8u16_decode u_decode (
        .i_byte  (r_in.byte_in),
        .i_last  (r_in.last_byte),
        .i_state (r_seq),
        .o_res   (dec)
    );

    // handshake
    assign out_acc    = o_out_valid && !i_out_stall;
    assign res_free   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && out_acc);
    assign consume    = r_in_vld && (res_free || dec.unit_cnt == 2'd0);
    assign o_in_stall = r_in_vld && !consume;
    assign in_acc     = i_in_valid && !o_in_stall;

    // output beat
    assign o_out_valid     = (r_cnt != 2'd0);
    assign o_out.code_unit = r_u0;
    assign o_out.last_unit = (r_cnt == 2'd1);

    // next-state logic
    always_comb begin
        n_in_vld = r_in_vld;
        n_in     = r_in;
        n_seq    = r_seq;
        n_cnt    = r_cnt;
        n_u0     = r_u0;
        n_u1     = r_u1;

        // drain the result register
        if (out_acc) begin
            if (r_cnt == 2'd2) begin
                n_cnt = 2'd1;
                n_u0  = r_u1;
            end else begin
                n_cnt = 2'd0;
            end
        end

        // move the decoded byte forward
        if (consume) begin
            n_seq    = dec.nxt;
            n_in_vld = 1'b0;
            if (dec.unit_cnt != 2'd0) begin
                n_cnt = dec.unit_cnt;
                n_u0  = dec.unit0;
                n_u1  = dec.unit1;
            end
        end

        // capture a new byte
        if (in_acc) begin
            n_in_vld = 1'b1;
            n_in     = i_in;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_cnt    <= 2'd0;
            r_seq    <= '0;
        end else begin
            r_in_vld <= n_in_vld;
            r_cnt    <= n_cnt;
            r_seq    <= n_seq;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_u0 <= n_u0;
        r_u1 <= n_u1;
    end

    // result register never holds more than two units
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    // a pair starts with a replacement or a high surrogate
    a_pair_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_u0 == u8u16_pkg::CP_REPLACEMENT ||
                             r_u0[15:10] == u8u16_pkg::HI_SURR_PREFIX))
        else $error("bad first unit of a pair");

    // second unit of a pair follows once the first is taken
    a_pair_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && out_acc) |=> (r_cnt == 2'd1 && r_u0 == $past(r_u1)))
        else $error("pair second unit lost");

    // trail count never exceeds the sequence length
    a_trail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.trail_remaining <= r_seq.sequence_trails)
        else $error("trail count above sequence length");

endmodule

[src/u8u16_decode.sv]
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte decode: folds one UTF-8 byte into the sequence state and forms
// zero, one or two UTF-16 code units.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  u8u16_pkg::t_seq_state i_state,
    output u8u16_pkg::t_dec_result o_res
);

    logic                  lead_unit_vld;
    logic [15:0]           lead_unit;
    logic                  lead_open;
    logic [2:0]            lead_trails;
    logic [4:0]            lead_bits;
    u8u16_pkg::t_seq_state lead_state;
    logic [30:0]           acc;
    logic [2:0]            tr_dec;
    logic [20:0]           supp;

    // lead byte classification
    always_comb begin
        lead_unit_vld = 1'b0;
        lead_unit     = u8u16_pkg::CP_REPLACEMENT;
        lead_open     = 1'b0;
        lead_trails   = 3'd0;
        lead_bits     = 5'd0;
        if (i_byte[7] == 1'b0) begin
            lead_unit_vld = 1'b1;
            lead_unit     = {8'h00, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            lead_open   = 1'b1;
            lead_trails = 3'd1;
            lead_bits   = i_byte[4:0];
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_open   = 1'b1;
            lead_trails = 3'd2;
            lead_bits   = {1'b0, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_open   = 1'b1;
            lead_trails = 3'd3;
            lead_bits   = {2'b00, i_byte[2:0]};
        end else if (i_byte[7:2] == 6'b111110) begin
            lead_open   = 1'b1;
            lead_trails = 3'd4;
            lead_bits   = {3'b000, i_byte[1:0]};
        end else if (i_byte[7:1] == 7'b1111110) begin
            lead_open   = 1'b1;
            lead_trails = 3'd5;
            lead_bits   = {4'b0000, i_byte[0]};
        end else begin
            lead_unit_vld = 1'b1;
        end

        // a multi-byte lead on the last byte is a cut-off sequence
        lead_state = '0;
        if (lead_open) begin
            if (i_last) begin
                lead_unit_vld = 1'b1;
                lead_unit     = u8u16_pkg::CP_REPLACEMENT;
            end else begin
                lead_state.partial_value   = {26'd0, lead_bits};
                lead_state.trail_remaining = lead_trails;
                lead_state.sequence_trails = lead_trails;
            end
        end
    end

    // trail accumulation and code point checks
    always_comb begin
        acc    = {i_state.partial_value[24:0], i_byte[5:0]};
        tr_dec = i_state.trail_remaining - 3'd1;
        supp   = acc[20:0] - u8u16_pkg::CP_SUPP_BASE;

        o_res       = '0;
        o_res.unit0 = u8u16_pkg::CP_REPLACEMENT;
        o_res.unit1 = u8u16_pkg::CP_REPLACEMENT;
        o_res.nxt   = i_state;

        if (i_state.trail_remaining != 3'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                if (tr_dec == 3'd0) begin
                    // sequence complete
                    o_res.nxt = '0;
                    if (i_state.sequence_trails >= 3'd4 ||
                        acc < u8u16_pkg::least_value(i_state.sequence_trails)) begin
                        o_res.unit_cnt = 2'd1;
                    end else if (acc < u8u16_pkg::CP_NONCHAR) begin
                        o_res.unit_cnt = 2'd1;
                        if (!(acc >= u8u16_pkg::CP_SURR_LO && acc <= u8u16_pkg::CP_SURR_HI)) begin
                            o_res.unit0 = acc[15:0];
                        end
                    end else if (acc <= 31'h0000FFFF || acc > u8u16_pkg::CP_MAX) begin
                        o_res.unit_cnt = 2'd1;
                    end else begin
                        // surrogate pair
                        o_res.unit_cnt = 2'd2;
                        o_res.unit0    = {u8u16_pkg::HI_SURR_PREFIX, supp[19:10]};
                        o_res.unit1    = {u8u16_pkg::LO_SURR_PREFIX, supp[9:0]};
                    end
                end else if (i_last) begin
                    // cut off mid-sequence
                    o_res.unit_cnt = 2'd1;
                    o_res.nxt      = '0;
                end else begin
                    o_res.nxt.partial_value   = acc;
                    o_res.nxt.trail_remaining = tr_dec;
                end
            end else begin
                // non-trail byte: replace, then decode as a new lead
                o_res.unit_cnt = lead_unit_vld ? 2'd2 : 2'd1;
                o_res.unit1    = lead_unit;
                o_res.nxt      = lead_state;
            end
        end else begin
            o_res.unit_cnt = lead_unit_vld ? 2'd1 : 2'd0;
            o_res.unit0    = lead_unit;
            o_res.nxt      = lead_state;
        end
    end

endmodule

[tb/tb_utf8_to_utf16_transcoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder_top
// Feeds UTF-8 byte beats into the transcoder and checks every UTF-16 unit
// against a cycle-free decoder model kept in a small scoreboard. A directed
// run covers the boundary and malformed forms, then a random run mixes
// well-formed code points, random lead/trail forms, broken sequences and
// noise. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_top;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_BYTES  = 650;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX    = 10;

    // byte class tags
    localparam logic [1:0] TRAIL_TAG = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [5:0] LEAD5_TAG = 6'b111110;
    localparam logic [6:0] LEAD6_TAG = 7'b1111110;

    // decoder model and queue of units still due from the block
    class unit_scoreboard;
        logic [30:0]           partial;
        logic [2:0]            trails_left;
        logic [2:0]            seq_trails;
        logic [15:0]           step_units[2];
        int                    step_cnt;
        u8u16_pkg::t_out_beat  due_units[$];
        int                    mismatches;

        function new();
            go_idle();
            mismatches = 0;
        endfunction

        function void go_idle();
            partial     = '0;
            trails_left = '0;
            seq_trails  = '0;
        endfunction

        function void add_unit(logic [15:0] u);
            step_units[step_cnt] = u;
            step_cnt++;
        endfunction

        function logic [30:0] least_for(logic [2:0] n);
            case (n)
                3'd1:    return 31'h80;
                3'd2:    return 31'h800;
                3'd3:    return 31'h10000;
                default: return '0;
            endcase
        endfunction

        // one unit, a surrogate pair, or the replacement
        function void emit_point(logic [30:0] cp);
            logic [30:0] v;
            if (cp < u8u16_pkg::CP_NONCHAR) begin
                if (cp >= u8u16_pkg::CP_SURR_LO && cp <= u8u16_pkg::CP_SURR_HI)
                    add_unit(u8u16_pkg::CP_REPLACEMENT);
                else add_unit(cp[15:0]);
            end else if (cp == u8u16_pkg::CP_NONCHAR || cp == u8u16_pkg::CP_NONCHAR + 31'd1 ||
                         cp > u8u16_pkg::CP_MAX) begin
                add_unit(u8u16_pkg::CP_REPLACEMENT);
            end else begin
                v = cp - 31'(u8u16_pkg::CP_SUPP_BASE);
                add_unit({u8u16_pkg::HI_SURR_PREFIX, v[19:10]});
                add_unit({u8u16_pkg::LO_SURR_PREFIX, v[9:0]});
            end
        endfunction

        // a lead byte that carries last cuts its own sequence off
        function void open_seq(logic [2:0] n, logic [30:0] bits, logic last);
            if (last) begin
                add_unit(u8u16_pkg::CP_REPLACEMENT);
                go_idle();
            end else begin
                partial     = bits;
                trails_left = n;
                seq_trails  = n;
            end
        endfunction

        function void decode_lead(logic [7:0] b, logic last);
            if (b[7] == 1'b0) add_unit({8'h00, b});
            else if (b[7:5] == LEAD2_TAG) open_seq(3'd1, 31'(b[4:0]), last);
            else if (b[7:4] == LEAD3_TAG) open_seq(3'd2, 31'(b[3:0]), last);
            else if (b[7:3] == LEAD4_TAG) open_seq(3'd3, 31'(b[2:0]), last);
            else if (b[7:2] == LEAD5_TAG) open_seq(3'd4, 31'(b[1:0]), last);
            else if (b[7:1] == LEAD6_TAG) open_seq(3'd5, 31'(b[0]), last);
            else add_unit(u8u16_pkg::CP_REPLACEMENT);
        endfunction

        // predict the units caused by one accepted byte beat
        function void note_byte(u8u16_pkg::t_in_beat beat);
            logic [7:0]           b;
            logic                 last;
            logic [2:0]           n;
            logic [30:0]          cp;
            u8u16_pkg::t_out_beat e;
            b        = beat.byte_in;
            last     = beat.last_byte;
            step_cnt = 0;
            if (trails_left != 0) begin
                if (b[7:6] == TRAIL_TAG) begin
                    partial     = {partial[24:0], b[5:0]};
                    trails_left = trails_left - 3'd1;
                    if (trails_left == 0) begin
                        n  = seq_trails;
                        cp = partial;
                        go_idle();
                        if (n >= 3'd4 || cp < least_for(n))
                            add_unit(u8u16_pkg::CP_REPLACEMENT);
                        else emit_point(cp);
                    end else if (last) begin
                        add_unit(u8u16_pkg::CP_REPLACEMENT);
                        go_idle();
                    end
                end else begin
                    // non-trail byte drops the sequence and starts over
                    add_unit(u8u16_pkg::CP_REPLACEMENT);
                    go_idle();
                    decode_lead(b, last);
                end
            end else begin
                decode_lead(b, last);
            end
            for (int i = 0; i < step_cnt; i++) begin
                e.code_unit = step_units[i];
                e.last_unit = (i == step_cnt - 1);
                due_units.push_back(e);
            end
        endfunction

        function void check_unit(u8u16_pkg::t_out_beat got);
            u8u16_pkg::t_out_beat want;
            if (due_units.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected unit %h last=%b, nothing due",
                             got.code_unit, got.last_unit);
                mismatches++;
            end else begin
                want = due_units.pop_front();
                if (got.code_unit !== want.code_unit || got.last_unit !== want.last_unit) begin
                    if (mismatches < REPORT_MAX)
                        $display("unit mismatch: expected %h last=%b, got %h last=%b",
                                 want.code_unit, want.last_unit,
                                 got.code_unit, got.last_unit);
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return due_units.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    u8u16_pkg::t_in_beat  i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    u8u16_pkg::t_out_beat o_out;

    unit_scoreboard sb = new();
    logic [8:0]     stream_bytes[$];
    int             cycle_cnt  = 0;
    int             stall_left = 0;
    int             calm_left  = 0;
    bit             out_calm   = 1'b0;

    utf8_to_utf16_transcoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // gap length, mostly short with a few long ones
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output stall with calm stretches
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            out_calm  <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(40, 300);
        end else begin
            calm_left <= calm_left - 1;
        end
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (!out_calm && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= gap_len() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // output beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_unit(o_out);
    end

    task automatic push_fixed(logic [7:0] b, logic last);
        stream_bytes.push_back({last, b});
    endtask

    task automatic push_byte(logic [7:0] b);
        stream_bytes.push_back({($urandom_range(0, 24) == 0), b});
    endtask

    function automatic logic [20:0] pick_code_point();
        int base;
        case ($urandom_range(0, 5))
            0: return 21'($urandom_range(0, 'h7F));
            1: return 21'($urandom_range('h80, 'h7FF));
            2: return 21'($urandom_range('h800, 'hFFFF));
            3: return 21'($urandom_range('h10000, 'h10FFFF));
            4: begin
                // one below, at, or one above a range boundary
                case ($urandom_range(0, 6))
                    0:       base = 'h80;
                    1:       base = 'h800;
                    2:       base = 'hD800;
                    3:       base = 'hE000;
                    4:       base = 'hFFFE;
                    5:       base = 'h10000;
                    default: base = 'h110000;
                endcase
                return 21'(base + int'($urandom_range(0, 2)) - 1);
            end
            default: return 21'($urandom_range('h110000, 'h1FFFFF));
        endcase
    endfunction

    // shortest-form encoding of a code point
    task automatic push_code_point(logic [20:0] cp);
        if (cp < 'h80) begin
            push_byte(cp[7:0]);
        end else if (cp < 'h800) begin
            push_byte({LEAD2_TAG, cp[10:6]});
            push_byte({TRAIL_TAG, cp[5:0]});
        end else if (cp < 'h10000) begin
            push_byte({LEAD3_TAG, cp[15:12]});
            push_byte({TRAIL_TAG, cp[11:6]});
            push_byte({TRAIL_TAG, cp[5:0]});
        end else begin
            push_byte({LEAD4_TAG, cp[20:18]});
            push_byte({TRAIL_TAG, cp[17:12]});
            push_byte({TRAIL_TAG, cp[11:6]});
            push_byte({TRAIL_TAG, cp[5:0]});
        end
    endtask

    // lead with random payload and random trails, optionally cut short
    task automatic push_random_form(bit broken);
        int          n;
        int          trails;
        logic [31:0] rnd;
        logic [7:0]  lead;
        n   = $urandom_range(1, 5);
        rnd = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
        case (n)
            1:       lead = {LEAD2_TAG, rnd[4:0]};
            2:       lead = {LEAD3_TAG, rnd[3:0]};
            3:       lead = {LEAD4_TAG, rnd[2:0]};
            4:       lead = {LEAD5_TAG, rnd[1:0]};
            default: lead = {LEAD6_TAG, rnd[0]};
        endcase
        trails = broken ? $urandom_range(0, n - 1) : n;
        push_byte(lead);
        repeat (trails) push_byte({TRAIL_TAG, 6'($urandom_range(0, 63))});
        if (broken) begin
            if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(0, 'h7F)));
            else push_byte(8'($urandom_range('hC0, 'hFF)));
        end
    endtask

    task automatic build_directed();
        // ascii extremes, the second one ends a stream
        push_fixed(8'h00, 1'b0); push_fixed(8'h7F, 1'b1);
        // overlong two-byte form
        push_fixed(8'hC0, 1'b0); push_fixed(8'h80, 1'b0);
        // surrogate value
        push_fixed(8'hED, 1'b0); push_fixed(8'hA0, 1'b0); push_fixed(8'h80, 1'b0);
        // highest code point, surrogate pair
        push_fixed(8'hF4, 1'b0); push_fixed(8'h8F, 1'b0);
        push_fixed(8'hBF, 1'b0); push_fixed(8'hBF, 1'b0);
        // lone trail byte and an invalid byte
        push_fixed(8'h80, 1'b0); push_fixed(8'hFF, 1'b0);
        // five-byte form
        push_fixed(8'hF8, 1'b0); push_fixed(8'h88, 1'b0); push_fixed(8'h80, 1'b0);
        push_fixed(8'h80, 1'b0); push_fixed(8'h80, 1'b0);
        // non-trail byte inside a sequence
        push_fixed(8'hE2, 1'b0); push_fixed(8'h41, 1'b0);
        // sequence cut off by end of stream, then a lead that ends a stream
        push_fixed(8'hE2, 1'b0); push_fixed(8'h82, 1'b1);
        push_fixed(8'hC3, 1'b1);
        // noncharacter FFFF completed on the final byte
        push_fixed(8'hEF, 1'b0); push_fixed(8'hBF, 1'b0); push_fixed(8'hBF, 1'b1);
    endtask

    task automatic build_random();
        while (stream_bytes.size() < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: push_code_point(pick_code_point());
                6, 7:             push_random_form(1'b0);
                8:                push_random_form(1'b1);
                default:          push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // drive one byte beat and hold it until accepted
    task automatic send_byte(logic [7:0] b, logic last, int gap);
        u8u16_pkg::t_in_beat beat;
        beat.byte_in   = b;
        beat.last_byte = last;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(beat);
    endtask

    // hold off the sender until every due unit has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic send_plan(bit drain_midway);
        int total;
        int gap;
        bit in_calm;
        total   = stream_bytes.size();
        in_calm = 1'b0;
        for (int k = 0; k < total; k++) begin
            if (k % 64 == 0) in_calm = ($urandom_range(0, 3) == 0);
            if (drain_midway && k == total / 2) wait_drained();
            gap = (in_calm || $urandom_range(0, 9) < 6) ? 0 : gap_len();
            send_byte(stream_bytes[k][7:0], stream_bytes[k][8], gap);
        end
        stream_bytes.delete();
    endtask

    // reset, directed run, random run, drain
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        build_directed();
        send_plan(1'b0);
        wait_drained();
        build_random();
        send_plan(1'b1);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
